### rtl/core/gsp_pkg.sv
// Shared types, codes and constants of the growing shape packer.
package gsp_pkg;

	localparam int unsigned MAX_SHAPES = 1024;
	localparam int unsigned IDX_W      = 10;
	localparam int unsigned CNT_W      = 11;
	localparam int unsigned COORD_W    = 12;
	localparam int unsigned CFG_W      = 13;
	localparam logic [CNT_W-1:0] CAPACITY = 11'd1024;
	localparam logic [CFG_W-1:0] WALL_MAX = 13'd4096;
	localparam logic [COORD_W-1:0] COORD_MAX = 12'd4095;

	typedef enum logic [2:0] {
		CMD_GROW   = 3'd0,
		CMD_PLACE  = 3'd1,
		CMD_SHRINK = 3'd2,
		CMD_READ   = 3'd3,
		CMD_CLEAR  = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_COLLIDED  = 2'd1,
		ST_FULL      = 2'd2,
		ST_OUT_RANGE = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		CFG_SCREEN_WIDTH  = 3'd0,
		CFG_SCREEN_HEIGHT = 3'd1,
		CFG_GROW_STEP     = 3'd2,
		CFG_GAP_SPACING   = 3'd3,
		CFG_BORDER_WIDTH  = 3'd4,
		CFG_CIRCLE_MODE   = 3'd5,
		CFG_LIVE_TARGET   = 3'd6
	} cfg_idx_t;

	typedef enum logic [2:0] {
		FIN_GROW, FIN_PLACE, FIN_FULL, FIN_SHRINK,
		FIN_READ, FIN_OUT_RANGE, FIN_CLEAR, FIN_NOP
	} fin_t;

	typedef enum logic [1:0] {
		RD_I, RD_J, RD_IDX
	} rdsel_t;

	typedef enum logic [3:0] {
		S_IDLE, S_DISPATCH, S_G_CHK, S_G_LD, S_SCAN, S_DRAIN,
		S_S_CHK, S_S_LD, S_R_WAIT, S_RESP
	} state_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] w;
		logic [COORD_W-1:0] h;
		logic               alive;
	} shape_t;

	typedef struct packed {
		logic [CFG_W-1:0] screen_width;
		logic [CFG_W-1:0] screen_height;
		logic [7:0]       grow_step;
		logic [7:0]       gap_spacing;
		logic [7:0]       border_width;
		logic             circle_mode;
		logic [CNT_W-1:0] live_target;
	} cfg_t;

	// controller to datapath
	typedef struct packed {
		logic   latch_in;
		logic   clr_i;
		logic   inc_i;
		logic   rd_en;
		rdsel_t rd_sel;
		logic   load_ram;
		logic   load_pt;
		logic   scan_start;
		logic   scan_step;
		logic   wr_grow;
		logic   wr_shrink;
		logic   finish;
		fin_t   fin;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		cmd_t cmd;
		logic full;
		logic out_range;
		logic i_end;
		logic j_end;
		logic pipe_empty;
		logic rd_alive;
		logic out_free;
	} dp_stat_t;

endpackage

### rtl/core/gsp_ram.sv
// Generic single write, single read RAM with registered read data.
module gsp_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/core/gsp_ctrl.sv
// Sequencer of the growing shape packer: walks commands through the datapath.
module gsp_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  gsp_pkg::dp_stat_t  st,
	output gsp_pkg::dp_cmd_t   cmd
);

	gsp_pkg::state_t state_q, state_d;
	gsp_pkg::fin_t   fin_q, fin_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gsp_pkg::S_IDLE;
			fin_q   <= gsp_pkg::FIN_NOP;
		end else begin
			state_q <= state_d;
			fin_q   <= fin_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		fin_d    = fin_q;
		cmd      = '0;
		cmd.fin  = fin_q;
		in_stall = 1'b1;
		unique case (state_q)
			gsp_pkg::S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					state_d      = gsp_pkg::S_DISPATCH;
				end
			end
			gsp_pkg::S_DISPATCH: begin
				unique case (st.cmd)
					gsp_pkg::CMD_GROW: begin
						cmd.clr_i = 1'b1;
						state_d   = gsp_pkg::S_G_CHK;
					end
					gsp_pkg::CMD_PLACE: begin
						if (st.full) begin
							fin_d   = gsp_pkg::FIN_FULL;
							state_d = gsp_pkg::S_RESP;
						end else begin
							cmd.load_pt    = 1'b1;
							cmd.scan_start = 1'b1;
							state_d        = gsp_pkg::S_SCAN;
						end
					end
					gsp_pkg::CMD_SHRINK: begin
						cmd.clr_i = 1'b1;
						state_d   = gsp_pkg::S_S_CHK;
					end
					gsp_pkg::CMD_READ: begin
						if (st.out_range) begin
							fin_d   = gsp_pkg::FIN_OUT_RANGE;
							state_d = gsp_pkg::S_RESP;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = gsp_pkg::RD_IDX;
							state_d    = gsp_pkg::S_R_WAIT;
						end
					end
					gsp_pkg::CMD_CLEAR: begin
						fin_d   = gsp_pkg::FIN_CLEAR;
						state_d = gsp_pkg::S_RESP;
					end
					default: begin
						fin_d   = gsp_pkg::FIN_NOP;
						state_d = gsp_pkg::S_RESP;
					end
				endcase
			end
			gsp_pkg::S_G_CHK: begin
				if (st.i_end) begin
					fin_d   = gsp_pkg::FIN_GROW;
					state_d = gsp_pkg::S_RESP;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = gsp_pkg::RD_I;
					state_d    = gsp_pkg::S_G_LD;
				end
			end
			gsp_pkg::S_G_LD: begin
				if (st.rd_alive) begin
					cmd.load_ram   = 1'b1;
					cmd.scan_start = 1'b1;
					state_d        = gsp_pkg::S_SCAN;
				end else begin
					cmd.inc_i = 1'b1;
					state_d   = gsp_pkg::S_G_CHK;
				end
			end
			gsp_pkg::S_SCAN: begin
				if (st.j_end) begin
					state_d = gsp_pkg::S_DRAIN;
				end else begin
					cmd.rd_en     = 1'b1;
					cmd.rd_sel    = gsp_pkg::RD_J;
					cmd.scan_step = 1'b1;
				end
			end
			gsp_pkg::S_DRAIN: begin
				if (st.pipe_empty) begin
					if (st.cmd == gsp_pkg::CMD_PLACE) begin
						fin_d   = gsp_pkg::FIN_PLACE;
						state_d = gsp_pkg::S_RESP;
					end else begin
						cmd.wr_grow = 1'b1;
						cmd.inc_i   = 1'b1;
						state_d     = gsp_pkg::S_G_CHK;
					end
				end
			end
			gsp_pkg::S_S_CHK: begin
				if (st.i_end) begin
					fin_d   = gsp_pkg::FIN_SHRINK;
					state_d = gsp_pkg::S_RESP;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = gsp_pkg::RD_I;
					state_d    = gsp_pkg::S_S_LD;
				end
			end
			gsp_pkg::S_S_LD: begin
				cmd.wr_shrink = 1'b1;
				cmd.inc_i     = 1'b1;
				state_d       = gsp_pkg::S_S_CHK;
			end
			gsp_pkg::S_R_WAIT: begin
				fin_d   = gsp_pkg::FIN_READ;
				state_d = gsp_pkg::S_RESP;
			end
			gsp_pkg::S_RESP: begin
				if (st.out_free) begin
					cmd.finish = 1'b1;
					state_d    = gsp_pkg::S_IDLE;
				end
			end
			default: state_d = gsp_pkg::S_IDLE;
		endcase
	end

endmodule

### rtl/core/gsp_dp.sv
// Datapath: shape table, counters, collision pipeline and result register.
module gsp_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  gsp_pkg::cfg_t                 cfg,
	input  logic [2:0]                    command,
	input  logic [gsp_pkg::COORD_W-1:0]   pos_x,
	input  logic [gsp_pkg::COORD_W-1:0]   pos_y,
	input  logic [gsp_pkg::IDX_W-1:0]     entry_index,
	input  gsp_pkg::dp_cmd_t              cmd,
	output gsp_pkg::dp_stat_t             st,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    status,
	output logic [gsp_pkg::CNT_W-1:0]     live_shapes,
	output logic [gsp_pkg::CNT_W-1:0]     entry_count,
	output logic                          needs_more,
	output logic [gsp_pkg::COORD_W-1:0]   read_x,
	output logic [gsp_pkg::COORD_W-1:0]   read_y,
	output logic [gsp_pkg::COORD_W-1:0]   read_w,
	output logic [gsp_pkg::COORD_W-1:0]   read_h,
	output logic                          read_alive
);

	localparam int unsigned CW = gsp_pkg::COORD_W;
	localparam int unsigned NW = gsp_pkg::CNT_W;
	localparam int unsigned AW = gsp_pkg::IDX_W;

	// latched command word
	logic [2:0]    cmd_q;
	logic [CW-1:0] px_q, py_q;
	logic [AW-1:0] idx_q;

	// table bookkeeping
	logic [NW-1:0] stored_q, alive_q, live_q, i_q, j_q;

	// candidate and collision flag
	gsp_pkg::shape_t cand_q;
	logic            cand_pt_q;
	logic            collide_q;

	// RAM port
	gsp_pkg::shape_t rdata, wdata;
	logic            we;
	logic [AW-1:0]   waddr, raddr;

	gsp_ram #(
		.WIDTH($bits(gsp_pkg::shape_t)),
		.DEPTH(gsp_pkg::MAX_SHAPES)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (cmd.rd_en),
		.raddr(raddr),
		.rdata(rdata)
	);

	// read address select
	always_comb begin
		unique case (cmd.rd_sel)
			gsp_pkg::RD_I:   raddr = i_q[AW-1:0];
			gsp_pkg::RD_J:   raddr = j_q[AW-1:0];
			gsp_pkg::RD_IDX: raddr = idx_q;
			default:         raddr = i_q[AW-1:0];
		endcase
	end

	// padding and wall limits
	logic [9:0]        pad;
	logic [CW:0]       lim_w, lim_h;
	assign pad   = 10'(cfg.grow_step) + 10'(cfg.gap_spacing) + 10'(cfg.border_width);
	assign lim_w = (cfg.screen_width  > gsp_pkg::WALL_MAX) ? gsp_pkg::WALL_MAX
	                                                       : cfg.screen_width;
	assign lim_h = (cfg.screen_height > gsp_pkg::WALL_MAX) ? gsp_pkg::WALL_MAX
	                                                       : cfg.screen_height;

	// wall test of the candidate being loaded
	gsp_pkg::shape_t nc;
	logic            wall_hit;
	logic [15:0]     far_x, far_y;
	always_comb begin
		if (cmd.load_pt) begin
			nc = '{x: px_q, y: py_q, w: '0, h: '0, alive: 1'b1};
		end else begin
			nc = rdata;
		end
		far_x    = 16'(nc.x) + 16'(nc.w) + {5'd0, pad, 1'b0};
		far_y    = 16'(nc.y) + 16'(nc.h) + {5'd0, pad, 1'b0};
		wall_hit = (16'(nc.x) < 16'(pad)) || (16'(nc.y) < 16'(pad)) ||
		           (far_x >= 16'(lim_w)) || (far_y >= 16'(lim_h));
	end

	// stage 1: read in flight
	logic p1_valid_q, p1_skip_q;
	// stage 2: square result and circle terms
	logic               v2_q, sq_hit_s2;
	logic signed [15:0] dx_s2, dy_s2, rs_s2;
	// stage 3: squares
	logic               v3_q, sq_hit_s3;
	logic signed [31:0] dx2_s3, dy2_s3, rs2_s3;

	// candidate versus table entry
	logic signed [15:0] ax, ay, aw, ah, bx, by, bw, bh, sp;
	logic signed [15:0] al, at, ar, ab, br_, bb, ml, mt, mr, mb, ra, rb;
	logic               sq_hit;
	always_comb begin
		ax  = 16'(cand_q.x);
		ay  = 16'(cand_q.y);
		aw  = 16'(cand_q.w);
		ah  = 16'(cand_q.h);
		bx  = 16'(rdata.x);
		by  = 16'(rdata.y);
		bw  = 16'(rdata.w);
		bh  = 16'(rdata.h);
		sp  = 16'(pad);
		al  = ax - sp;
		at  = ay - sp;
		ar  = ax + aw + sp + sp - 16'sd1;
		ab  = ay + ah + sp + sp - 16'sd1;
		br_ = bx + bw;
		bb  = by + bh;
		ml  = (al > bx) ? al : bx;
		mt  = (at > by) ? at : by;
		mr  = (ar < br_) ? ar : br_;
		mb  = (ab < bb) ? ab : bb;
		sq_hit = (mt < mb) && (ml < mr);
		ra  = aw >>> 1;
		rb  = bw >>> 1;
	end

	// collision pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p1_valid_q <= 1'b0;
			v2_q       <= 1'b0;
			v3_q       <= 1'b0;
		end else begin
			p1_valid_q <= cmd.scan_step;
			v2_q       <= p1_valid_q && !p1_skip_q;
			v3_q       <= v2_q;
		end
	end

	always_ff @(posedge clk) begin
		p1_skip_q <= !cand_pt_q && (j_q == i_q);
		sq_hit_s2 <= sq_hit;
		dx_s2     <= (bx + rb) - (ax + ra);
		dy_s2     <= (by + rb) - (ay + ra);
		rs_s2     <= ra + rb + sp;
		sq_hit_s3 <= sq_hit_s2;
		dx2_s3    <= dx_s2 * dx_s2;
		dy2_s3    <= dy_s2 * dy_s2;
		rs2_s3    <= rs_s2 * rs_s2;
	end

	logic hit3;
	assign hit3 = cfg.circle_mode ? ((dx2_s3 + dy2_s3) < rs2_s3) : sq_hit_s3;

	// shrink of the entry just read
	logic [8:0]    dstep;
	logic [CW:0]   sx, sy;
	gsp_pkg::shape_t shr;
	logic          shr_nz, shr_live;
	always_comb begin
		dstep  = {cfg.grow_step, 1'b0};
		sx     = 13'(rdata.x) + 13'(cfg.grow_step);
		sy     = 13'(rdata.y) + 13'(cfg.grow_step);
		shr_nz = (rdata.w != '0) && (rdata.h != '0);
		shr.x  = (sx > 13'(gsp_pkg::COORD_MAX)) ? gsp_pkg::COORD_MAX : sx[CW-1:0];
		shr.y  = (sy > 13'(gsp_pkg::COORD_MAX)) ? gsp_pkg::COORD_MAX : sy[CW-1:0];
		shr.w  = (rdata.w > 12'(dstep)) ? rdata.w - 12'(dstep) : '0;
		shr.h  = (rdata.h > 12'(dstep)) ? rdata.h - 12'(dstep) : '0;
		shr.alive = rdata.alive;
		shr_live  = shr_nz && (shr.w != '0) && (shr.h != '0);
	end

	// grown or killed candidate
	gsp_pkg::shape_t grown;
	always_comb begin
		grown = cand_q;
		if (collide_q) begin
			grown.alive = 1'b0;
		end else begin
			grown.x = cand_q.x - 12'(cfg.grow_step);
			grown.y = cand_q.y - 12'(cfg.grow_step);
			grown.w = cand_q.w + 12'(dstep);
			grown.h = cand_q.h + 12'(dstep);
		end
	end

	// table write port
	logic place_ok;
	assign place_ok = cmd.finish && (cmd.fin == gsp_pkg::FIN_PLACE) && !collide_q;
	always_comb begin
		we    = cmd.wr_grow || (cmd.wr_shrink && shr_nz) || place_ok;
		waddr = place_ok ? stored_q[AW-1:0] : i_q[AW-1:0];
		if (cmd.wr_grow) begin
			wdata = grown;
		end else if (cmd.wr_shrink) begin
			wdata = shr;
		end else begin
			wdata = '{x: px_q, y: py_q, w: '0, h: '0, alive: 1'b1};
		end
	end

	// output register
	logic out_valid_q;
	logic out_free;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	// result of the finishing command
	logic [1:0]    r_status;
	logic [NW-1:0] r_live, r_stored, r_alive;
	logic          r_rd;
	always_comb begin
		r_status = gsp_pkg::ST_OK;
		r_live   = alive_q;
		r_stored = stored_q;
		r_alive  = alive_q;
		r_rd     = 1'b0;
		unique case (cmd.fin)
			gsp_pkg::FIN_GROW: begin
				r_live  = live_q;
				r_alive = live_q;
			end
			gsp_pkg::FIN_PLACE: begin
				if (collide_q) begin
					r_status = gsp_pkg::ST_COLLIDED;
				end else begin
					r_stored = stored_q + 1'b1;
					r_alive  = alive_q + 1'b1;
					r_live   = alive_q + 1'b1;
				end
			end
			gsp_pkg::FIN_FULL:      r_status = gsp_pkg::ST_FULL;
			gsp_pkg::FIN_SHRINK: begin
				r_live = live_q;
				if (live_q == '0) begin
					r_stored = '0;
					r_alive  = '0;
				end
			end
			gsp_pkg::FIN_READ:      r_rd = 1'b1;
			gsp_pkg::FIN_OUT_RANGE: r_status = gsp_pkg::ST_OUT_RANGE;
			gsp_pkg::FIN_CLEAR: begin
				r_live   = '0;
				r_stored = '0;
				r_alive  = '0;
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_q    <= '0;
			alive_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				stored_q    <= r_stored;
				alive_q     <= r_alive;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// counters, candidate and command word
	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			cmd_q <= command;
			px_q  <= pos_x;
			py_q  <= pos_y;
			idx_q <= entry_index;
		end
		if (cmd.clr_i) begin
			i_q    <= '0;
			live_q <= '0;
		end else if (cmd.inc_i) begin
			i_q <= i_q + 1'b1;
		end
		if ((cmd.wr_grow && !collide_q) || (cmd.wr_shrink && shr_live)) begin
			live_q <= live_q + 1'b1;
		end
		if (cmd.load_pt || cmd.load_ram) begin
			cand_q    <= nc;
			cand_pt_q <= cmd.load_pt;
		end
		if (cmd.scan_start) begin
			j_q       <= '0;
			collide_q <= wall_hit;
		end else begin
			if (cmd.scan_step) begin
				j_q <= j_q + 1'b1;
			end
			if (v3_q && hit3) begin
				collide_q <= 1'b1;
			end
		end
		if (cmd.finish) begin
			status      <= r_status;
			live_shapes <= r_live;
			entry_count <= r_stored;
			needs_more  <= r_live < cfg.live_target;
			read_x      <= r_rd ? rdata.x : '0;
			read_y      <= r_rd ? rdata.y : '0;
			read_w      <= r_rd ? rdata.w : '0;
			read_h      <= r_rd ? rdata.h : '0;
			read_alive  <= r_rd ? rdata.alive : 1'b0;
		end
	end

	// status to the sequencer
	always_comb begin
		st.cmd        = gsp_pkg::cmd_t'(cmd_q);
		st.full       = stored_q >= gsp_pkg::CAPACITY;
		st.out_range  = NW'(idx_q) >= stored_q;
		st.i_end      = i_q >= stored_q;
		st.j_end      = j_q >= stored_q;
		st.pipe_empty = !p1_valid_q && !v2_q && !v3_q;
		st.rd_alive   = rdata.alive;
		st.out_free   = out_free;
	end

endmodule

### rtl/core/growing_shape_packer.sv
// Top level of the growing shape packer: configuration registers and core.
//
// Input channel: in_valid/in_stall carry one command word (command, pos_x,
// pos_y, entry_index). The block takes one word at a time and holds
// in_stall high until that word's result sits in the output register.
// Output channel: out_valid/out_stall carry one result word per command.
// The output register frees the input side: a new word is taken while the
// previous result still waits.
// Clear, spare codes and a place on a full table finish without a table scan;
// read fetches one entry. Place scans the table once. Grow runs one table
// scan per live entry and only checks the alive flag of a dead entry;
// entries are read one by one through the single RAM read port. Shrink
// visits each stored entry once.
// Configuration (cfg_write, cfg_index, cfg_data) is to be written only
// while idle; the user is bound by this, the block does not enforce it.
// Reset empties the table and loads the default screen and spacing values;
// table entries past the fill count are never read.
// A stalled receiver holds the result; the block then finishes its next
// command and waits with it until the output register is free.
module growing_shape_packer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [2:0]           command,
	input  logic [11:0]          pos_x,
	input  logic [11:0]          pos_y,
	input  logic [9:0]           entry_index,
	input  logic                 cfg_write,
	input  logic [2:0]           cfg_index,
	input  logic [12:0]          cfg_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           status,
	output logic [10:0]          live_shapes,
	output logic [10:0]          entry_count,
	output logic                 needs_more,
	output logic [11:0]          read_x,
	output logic [11:0]          read_y,
	output logic [11:0]          read_w,
	output logic [11:0]          read_h,
	output logic                 read_alive
);

	gsp_pkg::cfg_t     cfg_q;
	gsp_pkg::dp_cmd_t  dcmd;
	gsp_pkg::dp_stat_t dstat;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.screen_width  <= 13'd1024;
			cfg_q.screen_height <= 13'd768;
			cfg_q.grow_step     <= 8'd1;
			cfg_q.gap_spacing   <= 8'd1;
			cfg_q.border_width  <= 8'd1;
			cfg_q.circle_mode   <= 1'b0;
			cfg_q.live_target   <= 11'd50;
		end else if (cfg_write) begin
			unique case (cfg_index)
				gsp_pkg::CFG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_data;
				gsp_pkg::CFG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_data;
				gsp_pkg::CFG_GROW_STEP:     cfg_q.grow_step     <= cfg_data[7:0];
				gsp_pkg::CFG_GAP_SPACING:   cfg_q.gap_spacing   <= cfg_data[7:0];
				gsp_pkg::CFG_BORDER_WIDTH:  cfg_q.border_width  <= cfg_data[7:0];
				gsp_pkg::CFG_CIRCLE_MODE:   cfg_q.circle_mode   <= cfg_data[0];
				gsp_pkg::CFG_LIVE_TARGET:   cfg_q.live_target   <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	gsp_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.st      (dstat),
		.cmd     (dcmd)
	);

	gsp_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.command    (command),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.entry_index(entry_index),
		.cmd        (dcmd),
		.st         (dstat),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.live_shapes(live_shapes),
		.entry_count(entry_count),
		.needs_more (needs_more),
		.read_x     (read_x),
		.read_y     (read_y),
		.read_w     (read_w),
		.read_h     (read_h),
		.read_alive (read_alive)
	);

endmodule
